// ----- rtl/core/dess_pkg.sv -----
// Shared types, codes, decode table and speed scaling constants of the drive enable sequencer.
`timescale 1ns / 1ps
`default_nettype none

package dess_pkg;

    // Event codes on the input channel
    typedef enum logic [2:0] {
        CMD_STATUS     = 3'd0,
        CMD_VELOCITY   = 3'd1,
        CMD_BOOT       = 3'd2,
        CMD_QUERY      = 3'd3,
        CMD_QUICK_STOP = 3'd4
    } cmd_t;

    // Result action codes
    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_CW         = 3'd1,
        ACT_VEL_MODE   = 3'd2,
        ACT_TARGET_VEL = 3'd3,
        ACT_CONFIG     = 3'd4,
        ACT_GET_VEL    = 3'd5
    } action_t;

    // Drive power states, one-hot; bit position equals the decode table row
    typedef enum logic [7:0] {
        DS_NOT_READY  = 8'b0000_0001,
        DS_SW_ON_DIS  = 8'b0000_0010,
        DS_READY      = 8'b0000_0100,
        DS_SWITCHED   = 8'b0000_1000,
        DS_OP_ENABLED = 8'b0001_0000,
        DS_QSTOP      = 8'b0010_0000,
        DS_FAULT_RXN  = 8'b0100_0000,
        DS_FAULT      = 8'b1000_0000
    } drive_state_t;

    localparam int unsigned NUM_STATES = 8;

    // Status word decode, first match wins
    localparam logic [7:0] DECODE_MASK [NUM_STATES] =
        '{8'h4F, 8'h4F, 8'h6F, 8'h6F, 8'h6F, 8'h6F, 8'h4F, 8'h4F};
    localparam logic [7:0] DECODE_VALUE [NUM_STATES] =
        '{8'h00, 8'h40, 8'h21, 8'h23, 8'h27, 8'h07, 8'h0F, 8'h08};

    localparam logic [10:0] COB_ID_STATUS = 11'h180;

    // Control words
    localparam logic [7:0] CTL_SHUTDOWN    = 8'h06;
    localparam logic [7:0] CTL_SWITCH_ON   = 8'h07;
    localparam logic [7:0] CTL_ENABLE_OP   = 8'h0F;
    localparam logic [7:0] CTL_QSTOP       = 8'h02;
    localparam logic [7:0] CTL_FLT_RESET   = 8'h80;
    localparam logic [7:0] CTL_DIS_VOLTAGE = 8'h00;

    // Speed scaling: T = floor(|v| * 66666667 * 65535 / 7680000000) = floor(|v| * C >> 44)
    // with C rounded up; the error stays below one step for |v| up to 2^15.
    localparam int unsigned  SCALE_SHIFT     = 44;
    localparam logic [127:0] SCALE_NUM_WIDE  = (128'd66666667 * 128'd65535) << SCALE_SHIFT;
    localparam logic [127:0] SCALE_DEN_WIDE  = 128'd7680000000;
    localparam logic [127:0] SCALE_RECIP_WIDE =
        (SCALE_NUM_WIDE + SCALE_DEN_WIDE - 128'd1) / SCALE_DEN_WIDE;
    localparam logic [53:0]  SCALE_RECIP     = SCALE_RECIP_WIDE[53:0];
    localparam logic [26:0]  SCALE_RECIP_HI  = SCALE_RECIP[53:27];
    localparam logic [26:0]  SCALE_RECIP_LO  = SCALE_RECIP[26:0];

    localparam logic [16:0] FRAC_DIV = 17'd65535;

    // Results planned for one transaction (one or two)
    typedef struct packed {
        logic          two;
        action_t       act0;
        logic [7:0]    cw0;
        action_t       act1;
        logic [7:0]    cw1;
        logic          neg;
    } plan_t;

    // Plan plus scaled speed, 65535 * pulses per ms, truncated
    typedef struct packed {
        plan_t         plan;
        logic [24:0]   scaled;
    } scaled_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/dess_control.sv -----
// Drive state register, status word decode and result planning per transaction.
`timescale 1ns / 1ps
`default_nettype none

module dess_control (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 accept,
    input  wire logic [2:0]           cmd,
    input  wire logic [10:0]          cob_id,
    input  wire logic [15:0]          stat_word,
    input  wire logic signed [15:0]   velocity,
    output dess_pkg::plan_t           plan,
    output logic                      has_result,
    output logic [16:0]               mag
);
    import dess_pkg::*;

    drive_state_t drive_state_reg;
    drive_state_t drive_state_next;
    drive_state_t decoded_state;
    logic         decode_found;
    logic [7:0]   decoded_onehot;
    logic [16:0]  vel_mag;

    // First matching mask/value pair
    always_comb begin
        decode_found   = 1'b0;
        decoded_onehot = 8'd0;
        for (int i = NUM_STATES - 1; i >= 0; i--) begin
            if ((stat_word[7:0] & DECODE_MASK[i]) == DECODE_VALUE[i]) begin
                decode_found   = 1'b1;
                decoded_onehot = 8'd1 << i;
            end
        end
        decoded_state = drive_state_t'(decoded_onehot);
    end

    // Magnitude of the commanded speed; -32768 gives 32768
    assign vel_mag = velocity[15] ? (17'h10000 - {1'b0, velocity}) : {1'b0, velocity};

    // Plan the results and the next drive state
    always_comb begin
        plan             = '0;
        plan.act0        = ACT_NONE;
        plan.act1        = ACT_NONE;
        has_result       = 1'b0;
        mag              = '0;
        drive_state_next = drive_state_reg;
        case (cmd_t'(cmd))
            CMD_STATUS: begin
                if (cob_id == COB_ID_STATUS && decode_found) begin
                    drive_state_next = decoded_state;
                    if (decoded_state == DS_FAULT) begin
                        has_result = 1'b1;
                        plan.two   = 1'b1;
                        plan.act0  = ACT_CW;
                        plan.cw0   = CTL_FLT_RESET;
                        plan.act1  = ACT_CW;
                        plan.cw1   = CTL_DIS_VOLTAGE;
                    end else if (decoded_state == DS_SW_ON_DIS) begin
                        has_result = 1'b1;
                        plan.act0  = ACT_CW;
                        plan.cw0   = CTL_SHUTDOWN;
                    end else if (decoded_state == DS_READY) begin
                        has_result = 1'b1;
                        plan.act0  = ACT_CW;
                        plan.cw0   = CTL_SWITCH_ON;
                    end else if (decoded_state == DS_SWITCHED) begin
                        has_result = 1'b1;
                        plan.act0  = ACT_CW;
                        plan.cw0   = CTL_ENABLE_OP;
                    end else if (decoded_state == DS_OP_ENABLED
                                 && drive_state_reg == DS_SWITCHED) begin
                        has_result = 1'b1;
                        plan.act0  = ACT_VEL_MODE;
                    end
                end
            end
            CMD_VELOCITY: begin
                if (drive_state_reg == DS_SW_ON_DIS) begin
                    has_result = 1'b1;
                    plan.act0  = ACT_CW;
                    plan.cw0   = CTL_SHUTDOWN;
                end else if (drive_state_reg == DS_OP_ENABLED) begin
                    has_result = 1'b1;
                    plan.act0  = ACT_TARGET_VEL;
                    plan.neg   = velocity[15];
                    mag        = vel_mag;
                end
            end
            CMD_BOOT: begin
                has_result = 1'b1;
                plan.act0  = ACT_CONFIG;
            end
            CMD_QUERY: begin
                has_result = 1'b1;
                plan.act0  = ACT_GET_VEL;
            end
            CMD_QUICK_STOP: begin
                // quick stop word, then shutdown (switch on disabled) or zero velocity (operation enabled)
                has_result = 1'b1;
                plan.act0  = ACT_CW;
                plan.cw0   = CTL_QSTOP;
                if (drive_state_reg == DS_SW_ON_DIS) begin
                    plan.two  = 1'b1;
                    plan.act1 = ACT_CW;
                    plan.cw1  = CTL_SHUTDOWN;
                end else if (drive_state_reg == DS_OP_ENABLED) begin
                    plan.two  = 1'b1;
                    plan.act1 = ACT_TARGET_VEL;
                end
            end
            default: begin
                has_result = 1'b0;
            end
        endcase
    end

    // Kept drive state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_state_reg <= DS_NOT_READY;
        end else if (accept) begin
            drive_state_reg <= drive_state_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/dess_scale.sv -----
// Two-stage speed scaling pipeline: split-constant multiply, then sum and shift.
`timescale 1ns / 1ps
`default_nettype none

module dess_scale (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire dess_pkg::plan_t        in_plan,
    input  wire logic [16:0]            in_mag,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output dess_pkg::scaled_item_t      out_item
);
    import dess_pkg::*;

    logic          s1_valid_reg;
    plan_t         s1_plan_reg;
    logic [43:0]   s1_prod_hi_reg;
    logic [43:0]   s1_prod_lo_reg;
    logic          s2_valid_reg;
    scaled_item_t  s2_item_reg;
    logic          s1_en;
    logic          s2_en;
    logic [70:0]   prod_sum;

    // Stage enables; empty stages fill even while downstream stalls
    assign s2_en    = out_ready || !s2_valid_reg;
    assign s1_en    = s2_en || !s1_valid_reg;
    assign in_ready = s1_en;

    assign prod_sum = {s1_prod_hi_reg, 27'd0} + {27'd0, s1_prod_lo_reg};

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_en) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_en) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Stage 1: partial products of the magnitude and the reciprocal constant
    always_ff @(posedge aclk) begin
        if (s1_en && in_valid) begin
            s1_plan_reg    <= in_plan;
            s1_prod_hi_reg <= {27'd0, in_mag} * {17'd0, SCALE_RECIP_HI};
            s1_prod_lo_reg <= {27'd0, in_mag} * {17'd0, SCALE_RECIP_LO};
        end
    end

    // Stage 2: combine partial products and drop the fraction bits
    always_ff @(posedge aclk) begin
        if (s2_en && s1_valid_reg) begin
            s2_item_reg.plan   <= s1_plan_reg;
            s2_item_reg.scaled <= prod_sum[68:44];
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_item_reg;

endmodule

`default_nettype wire

// ----- rtl/core/dess_outbuf.sv -----
// Result register: splits the scaled speed and sends one or two results per transaction.
`timescale 1ns / 1ps
`default_nettype none

module dess_outbuf (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire dess_pkg::scaled_item_t in_item,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [2:0]                  m_action,
    output logic [7:0]                  m_control_word,
    output logic                        m_polarity_negative,
    output logic [8:0]                  m_speed_integer,
    output logic [15:0]                 m_speed_fraction,
    output logic                        m_last
);
    import dess_pkg::*;

    logic          m_valid_reg;
    logic          pend_reg;
    action_t       act_reg;
    logic [7:0]    cw_reg;
    action_t       act1_reg;
    logic [7:0]    cw1_reg;
    logic          neg_reg;
    logic [8:0]    int_reg;
    logic [15:0]   frac_reg;
    logic          load;
    logic          is_target;
    logic [8:0]    quot_est;
    logic [16:0]   rem_est;
    logic [8:0]    int_next;
    logic [15:0]   frac_next;

    // Free when empty or when the last result leaves this cycle
    assign load     = !m_valid_reg || (m_ready && !pend_reg);
    assign in_ready = load;

    // Divide by 65535: T = q*65536 + lo = q*65535 + (lo + q), one correction step
    always_comb begin
        quot_est = in_item.scaled[24:16];
        rem_est  = {1'b0, in_item.scaled[15:0]} + {8'd0, quot_est};
        if (rem_est >= FRAC_DIV) begin
            int_next  = quot_est + 9'd1;
            frac_next = 16'(rem_est - FRAC_DIV);
        end else begin
            int_next  = quot_est;
            frac_next = rem_est[15:0];
        end
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else if (load) begin
            m_valid_reg <= in_valid;
            pend_reg    <= in_valid && in_item.plan.two;
        end else if (m_ready) begin
            pend_reg    <= 1'b0;
        end
    end

    // Payload; the second result moves to the front after the first is taken
    always_ff @(posedge aclk) begin
        if (load && in_valid) begin
            act_reg  <= in_item.plan.act0;
            cw_reg   <= in_item.plan.cw0;
            act1_reg <= in_item.plan.act1;
            cw1_reg  <= in_item.plan.cw1;
            neg_reg  <= in_item.plan.neg;
            int_reg  <= int_next;
            frac_reg <= frac_next;
        end else if (m_valid_reg && m_ready && pend_reg) begin
            act_reg  <= act1_reg;
            cw_reg   <= cw1_reg;
        end
    end

    assign is_target           = (act_reg == ACT_TARGET_VEL);
    assign m_valid             = m_valid_reg;
    assign m_action            = act_reg;
    assign m_control_word      = cw_reg;
    assign m_polarity_negative = is_target && neg_reg;
    assign m_speed_integer     = is_target ? int_reg : 9'd0;
    assign m_speed_fraction    = is_target ? frac_reg : 16'd0;
    assign m_last              = !pend_reg;

endmodule

`default_nettype wire

// ----- rtl/core/drive_enable_state_sequencer.sv -----
// Drive enable sequencer top level: control, speed scaling pipeline and result register.
//
// Usage: each s_ transaction is one event (status word, velocity command, boot-up,
// velocity query or quick stop). Status words decode into a drive power state, and
// the block answers on the m_ channel with zero, one or two result transactions
// (control word, velocity mode, target velocity, node configuration, velocity
// request); m_last marks the final result of an event.
// Path: an accepted event passes the two scaling stages and then the result register
// before its result is presented. Throughput: one event per cycle when it yields at
// most one result and the receiver does not stall; an event that yields two results
// holds the single result register until both are taken.
// Events with no result are accepted and leave the pipeline empty.
// Reset (aresetn low, synchronous) sets the drive state to not ready to switch on
// and empties the pipeline. When the receiver stalls, results hold steady; empty
// stages keep filling, and s_ready drops only once all three stages are full.
`timescale 1ns / 1ps
`default_nettype none

module drive_enable_state_sequencer (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [2:0]           s_cmd,
    input  wire logic [10:0]          s_cob_id,
    input  wire logic [15:0]          s_stat_word,
    input  wire logic signed [15:0]   s_velocity,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [2:0]                m_action,
    output logic [7:0]                m_control_word,
    output logic                      m_polarity_negative,
    output logic [8:0]                m_speed_integer,
    output logic [15:0]               m_speed_fraction,
    output logic                      m_last
);
    import dess_pkg::*;

    logic          accept;
    plan_t         plan;
    logic          has_result;
    logic [16:0]   mag;
    logic          scale_ready;
    logic          scaled_valid;
    logic          outbuf_ready;
    scaled_item_t  scaled_item;

    assign s_ready = scale_ready;
    assign accept  = s_valid && scale_ready;

    // Event decode and drive state
    dess_control u_control (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .cmd         (s_cmd),
        .cob_id      (s_cob_id),
        .stat_word   (s_stat_word),
        .velocity    (s_velocity),
        .plan        (plan),
        .has_result  (has_result),
        .mag         (mag)
    );

    // Speed scaling stages; only events with results enter
    dess_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid && has_result),
        .in_ready  (scale_ready),
        .in_plan   (plan),
        .in_mag    (mag),
        .out_valid (scaled_valid),
        .out_ready (outbuf_ready),
        .out_item  (scaled_item)
    );

    // Result register and two-result sequencing
    dess_outbuf u_outbuf (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .in_valid            (scaled_valid),
        .in_ready            (outbuf_ready),
        .in_item             (scaled_item),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_action            (m_action),
        .m_control_word      (m_control_word),
        .m_polarity_negative (m_polarity_negative),
        .m_speed_integer     (m_speed_integer),
        .m_speed_fraction    (m_speed_fraction),
        .m_last              (m_last)
    );

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking regression bench for the drive enable sequencer.
`timescale 1ns / 1ps

module testbench;
    import dess_pkg::*;

    localparam int unsigned     WATCHDOG_LIMIT  = 2000;
    localparam int unsigned     DRAIN_CYCLES    = 12;
    localparam int unsigned     HOLD_OFF_CYCLES = 80;
    localparam int unsigned     REPORT_LIMIT    = 100;
    localparam longint unsigned RPM_SCALE_NUM   = 64'd66666667;
    localparam longint unsigned PULSE_SCALE_DEN = 64'd7680000000;
    localparam logic [15:0]     FRAC_FULL_SCALE = 16'd65535;
    // event codes the block must ignore
    localparam logic [2:0]      CMD_UNUSED_LO   = 3'd5;
    localparam logic [2:0]      CMD_UNUSED_HI   = 3'd7;

    typedef struct {
        action_t     action;
        logic [7:0]  control_word;
        logic        polarity_negative;
        logic [8:0]  speed_integer;
        logic [15:0] speed_fraction;
        logic        last;
    } drive_result_t;

    // Tracks the drive state and commanded speed, and queues the results
    // each accepted event should produce.
    class drive_sequencer_scoreboard;
        drive_state_t  drive_state     = DS_NOT_READY;
        logic [15:0]   commanded_speed = '0;
        drive_result_t expected_results[$];
        int            errors          = 0;
        int            reports         = 0;

        function void push_result(action_t act, logic [7:0] cw, logic neg,
                                  logic [8:0] whole_part, logic [15:0] frac_part);
            drive_result_t r;
            r.action            = act;
            r.control_word      = cw;
            r.polarity_negative = neg;
            r.speed_integer     = whole_part;
            r.speed_fraction    = frac_part;
            r.last              = 1'b0;
            expected_results.push_back(r);
        endfunction

        // rpm to pulses per ms, 9.16 with the fraction scaled by 65535
        function void push_scaled_speed();
            logic            neg;
            logic [16:0]     magnitude;
            longint unsigned product;
            longint unsigned whole;
            longint unsigned remainder;
            longint unsigned fraction;
            neg       = commanded_speed[15];
            magnitude = neg ? 17'h10000 - {1'b0, commanded_speed} : {1'b0, commanded_speed};
            product   = magnitude;
            product   = product * RPM_SCALE_NUM;
            whole     = product / PULSE_SCALE_DEN;
            remainder = product % PULSE_SCALE_DEN;
            fraction  = (remainder * FRAC_FULL_SCALE) / PULSE_SCALE_DEN;
            push_result(ACT_TARGET_VEL, 8'h00, neg, whole[8:0], fraction[15:0]);
        endfunction

        function void apply_velocity(logic [15:0] speed);
            commanded_speed = speed;
            if (drive_state == DS_SW_ON_DIS)
                push_result(ACT_CW, CTL_SHUTDOWN, 1'b0, '0, '0);
            else if (drive_state == DS_OP_ENABLED)
                push_scaled_speed();
        endfunction

        // first matching mask/value row gives the new state
        function void apply_status(logic [15:0] sw);
            drive_state_t next_state;
            bit           found;
            next_state = drive_state;
            found      = 1'b0;
            for (int i = 0; i < NUM_STATES; i++) begin
                if (!found && (sw[7:0] & DECODE_MASK[i]) == DECODE_VALUE[i]) begin
                    next_state = drive_state_t'(8'd1 << i);
                    found      = 1'b1;
                end
            end
            if (!found)
                return;
            if (next_state == DS_READY && drive_state == DS_SW_ON_DIS)
                push_result(ACT_CW, CTL_SWITCH_ON, 1'b0, '0, '0);
            else if (next_state == DS_SWITCHED && drive_state == DS_READY)
                push_result(ACT_CW, CTL_ENABLE_OP, 1'b0, '0, '0);
            else if (next_state == DS_OP_ENABLED && drive_state == DS_SWITCHED)
                push_result(ACT_VEL_MODE, 8'h00, 1'b0, '0, '0);
            else if (next_state == DS_FAULT) begin
                push_result(ACT_CW, CTL_FLT_RESET, 1'b0, '0, '0);
                push_result(ACT_CW, CTL_DIS_VOLTAGE, 1'b0, '0, '0);
            end else if (next_state == DS_SW_ON_DIS)
                push_result(ACT_CW, CTL_SHUTDOWN, 1'b0, '0, '0);
            else if (next_state == DS_SWITCHED)
                push_result(ACT_CW, CTL_ENABLE_OP, 1'b0, '0, '0);
            else if (next_state == DS_READY)
                push_result(ACT_CW, CTL_SWITCH_ON, 1'b0, '0, '0);
            drive_state = next_state;
        endfunction

        function void note_event(logic [2:0] cmd, logic [10:0] cob, logic [15:0] sw,
                                 logic [15:0] speed);
            int start_count;
            start_count = expected_results.size();
            case (cmd)
                CMD_STATUS: begin
                    if (cob == COB_ID_STATUS)
                        apply_status(sw);
                end
                CMD_VELOCITY: apply_velocity(speed);
                CMD_BOOT:     push_result(ACT_CONFIG, 8'h00, 1'b0, '0, '0);
                CMD_QUERY:    push_result(ACT_GET_VEL, 8'h00, 1'b0, '0, '0);
                CMD_QUICK_STOP: begin
                    push_result(ACT_CW, CTL_QSTOP, 1'b0, '0, '0);
                    apply_velocity(16'h0000);
                end
                default: ;
            endcase
            if (expected_results.size() > start_count)
                expected_results[expected_results.size() - 1].last = 1'b1;
        endfunction

        function void check_result(drive_result_t got);
            drive_result_t want;
            if (expected_results.size() == 0) begin
                errors++;
                if (reports++ < REPORT_LIMIT)
                    $display("%0t: unexpected result: action %0d cw %h", $time,
                             got.action, got.control_word);
                return;
            end
            want = expected_results.pop_front();
            if (got.action !== want.action || got.control_word !== want.control_word
                || got.polarity_negative !== want.polarity_negative
                || got.speed_integer !== want.speed_integer
                || got.speed_fraction !== want.speed_fraction || got.last !== want.last) begin
                errors++;
                if (reports++ < REPORT_LIMIT)
                    $display({"%0t: mismatch: expected act %0d cw %h neg %b int %0d frac %0d",
                              " last %b, actual act %0d cw %h neg %b int %0d frac %0d last %b"},
                             $time, want.action, want.control_word, want.polarity_negative,
                             want.speed_integer, want.speed_fraction, want.last,
                             got.action, got.control_word, got.polarity_negative,
                             got.speed_integer, got.speed_fraction, got.last);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_cmd;
    logic [10:0] s_cob_id;
    logic [15:0] s_stat_word;
    logic [15:0] s_velocity;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_action;
    logic [7:0]  m_control_word;
    logic        m_polarity_negative;
    logic [8:0]  m_speed_integer;
    logic [15:0] m_speed_fraction;
    logic        m_last;

    drive_sequencer_scoreboard scoreboard = new();

    int unsigned sender_idle_pct   = 0;
    int unsigned receiver_idle_pct = 0;
    int unsigned events_sent       = 0;
    int unsigned quiet_cycles      = 0;
    bit          hold_off_request  = 1'b0;

    drive_enable_state_sequencer uut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_cmd               (s_cmd),
        .s_cob_id            (s_cob_id),
        .s_stat_word         (s_stat_word),
        .s_velocity          (s_velocity),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_action            (m_action),
        .m_control_word      (m_control_word),
        .m_polarity_negative (m_polarity_negative),
        .m_speed_integer     (m_speed_integer),
        .m_speed_fraction    (m_speed_fraction),
        .m_last              (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Receiver: random backpressure, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_request = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Result checking and watchdog
    always @(posedge aclk) begin
        drive_result_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.action            = action_t'(m_action);
                got.control_word      = m_control_word;
                got.polarity_negative = m_polarity_negative;
                got.speed_integer     = m_speed_integer;
                got.speed_fraction    = m_speed_fraction;
                got.last              = m_last;
                scoreboard.check_result(got);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d results outstanding", $time,
                         scoreboard.pending());
                $display("drive_enable_state_sequencer regression: fail");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high.
    task automatic send_event(input logic [2:0] cmd, input logic [10:0] cob,
                              input logic [15:0] sw, input logic [15:0] speed);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_cob_id    <= cob;
        s_stat_word <= sw;
        s_velocity  <= speed;
        do @(posedge aclk); while (!s_ready);
        scoreboard.note_event(cmd, cob, sw, speed);
        events_sent++;
        @(negedge aclk);
    endtask

    // random word that decodes to the given state, free bits scrambled
    function automatic logic [15:0] stat_word_for(drive_state_t st);
        logic [15:0] word;
        word = 16'($urandom);
        for (int i = 0; i < NUM_STATES; i++)
            if (st[i])
                word = (word & ~{8'h00, DECODE_MASK[i]}) | {8'h00, DECODE_VALUE[i]};
        return word;
    endfunction

    function automatic logic [15:0] random_speed();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_status(drive_state_t st);
        send_event(CMD_STATUS, COB_ID_STATUS, stat_word_for(st), 16'($urandom));
    endtask

    task automatic send_plain(logic [2:0] cmd);
        send_event(cmd, 11'($urandom), 16'($urandom), random_speed());
    endtask

    // Edge cases and a full bring-up, fault and recovery
    task automatic run_directed();
        send_event(CMD_VELOCITY, 11'h000, 16'h0000, 16'h8000);   // stored, not ready
        send_event(CMD_UNUSED_LO, COB_ID_STATUS, 16'h0040, 16'h1234);
        send_event(CMD_UNUSED_HI, 11'h7FF, 16'hFFFF, 16'hFFFF);
        send_event(CMD_STATUS, 11'h181, 16'h0040, 16'h0000);     // foreign id
        send_event(CMD_STATUS, 11'h7FF, 16'h0040, 16'h0000);
        send_event(CMD_STATUS, COB_ID_STATUS, 16'h0000, 16'h0000);
        send_event(CMD_STATUS, COB_ID_STATUS, 16'hFFFF, 16'h0000); // no row matches
        send_event(CMD_STATUS, COB_ID_STATUS, 16'h0040, 16'h0000);
        send_event(CMD_VELOCITY, 11'h000, 16'h0000, 16'h7FFF);   // shutdown
        send_event(CMD_QUICK_STOP, 11'h000, 16'h0000, 16'h0000);
        send_event(CMD_STATUS, COB_ID_STATUS, 16'h0021, 16'h0000);
        send_event(CMD_STATUS, COB_ID_STATUS, 16'h0023, 16'h0000);
        send_event(CMD_STATUS, COB_ID_STATUS, 16'h0027, 16'h0000);
        send_event(CMD_VELOCITY, 11'h000, 16'h0000, 16'h7FFF);
        send_event(CMD_VELOCITY, 11'h000, 16'h0000, 16'h8000);
        send_event(CMD_VELOCITY, 11'h000, 16'h0000, 16'h0000);
        send_event(CMD_VELOCITY, 11'h000, 16'h0000, 16'hFFFF);
        send_event(CMD_VELOCITY, 11'h000, 16'h0000, 16'h0001);
        send_event(CMD_BOOT, 11'h000, 16'h0000, 16'h0000);
        send_event(CMD_QUERY, 11'h7FF, 16'hFFFF, 16'hFFFF);
        send_event(CMD_QUICK_STOP, 11'h000, 16'h0000, 16'h0000); // two results
        send_event(CMD_STATUS, COB_ID_STATUS, 16'h0007, 16'h0000);
        send_event(CMD_STATUS, COB_ID_STATUS, 16'h000F, 16'h0000);
        send_event(CMD_STATUS, COB_ID_STATUS, 16'h0008, 16'h0000); // fault
        send_event(CMD_QUICK_STOP, 11'h000, 16'h0000, 16'h0000);
        send_event(CMD_STATUS, COB_ID_STATUS, 16'hFF23, 16'h0000);
        send_event(CMD_STATUS, COB_ID_STATUS, 16'hFFA1, 16'h0000);
    endtask

    // Mostly bring-up sequences with random content, the rest noise
    task automatic run_random(int unsigned target);
        while (events_sent < target) begin
            if ($urandom_range(99) < 75) begin
                if ($urandom_range(3) == 0)
                    send_status(DS_FAULT);
                if ($urandom_range(9) != 0) send_status(DS_SW_ON_DIS);
                if ($urandom_range(9) != 0) send_status(DS_READY);
                if ($urandom_range(9) != 0) send_status(DS_SWITCHED);
                if ($urandom_range(9) != 0) send_status(DS_OP_ENABLED);
                repeat ($urandom_range(1, 8)) begin
                    case ($urandom_range(9))
                        5:       send_plain(CMD_QUERY);
                        6:       send_plain(CMD_BOOT);
                        7:       send_plain(CMD_QUICK_STOP);
                        8:       send_status(drive_state_t'(8'd1 << $urandom_range(7)));
                        9:       send_status(DS_OP_ENABLED);
                        default: send_plain(CMD_VELOCITY);
                    endcase
                end
            end else begin
                send_event(3'($urandom_range(7)),
                           ($urandom_range(1) == 0) ? COB_ID_STATUS : 11'($urandom),
                           16'($urandom), random_speed());
            end
        end
    endtask

    // Stimulus and end of run
    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_cmd       = '0;
        s_cob_id    = '0;
        s_stat_word = '0;
        s_velocity  = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        sender_idle_pct   = 25;
        receiver_idle_pct = 88;
        run_directed();
        run_random(420);

        sender_idle_pct   = 88;
        receiver_idle_pct = 25;
        run_random(840);

        // receiver stalls while the sender keeps pushing
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_off_request  = 1'b1;
        repeat (24) send_plain(CMD_BOOT);
        wait (!hold_off_request);
        run_random(1250);

        s_valid <= 1'b0;
        while (scoreboard.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (scoreboard.errors == 0 && scoreboard.pending() == 0)
            $display("drive_enable_state_sequencer regression: pass");
        else
            $display("drive_enable_state_sequencer regression: fail");
        $finish;
    end

endmodule
